FILE: rtl/crop_pkg.sv
`default_nettype none

package crop_pkg;

    // Field limits of the option layout.
    localparam logic [5:0] MAX_PREFIX    = 6'd32;
    localparam logic [2:0] ROUTER_OCTETS = 3'd4;
    localparam logic [9:0] INDEX_MAX     = 10'd1023;

    // Where the parser stands inside the current entry.
    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_DEST   = 2'd1,
        PH_ROUTER = 2'd2,
        PH_DROP   = 2'd3
    } t_phase;

    // Result codes carried in result_kind.
    localparam logic [1:0] KIND_ROUTE      = 2'd0;
    localparam logic [1:0] KIND_BAD_PREFIX = 2'd1;
    localparam logic [1:0] KIND_OVERRUN    = 2'd2;

    // One input word: a byte of option data and its end marker.
    typedef struct packed {
        logic [7:0] option_byte;
        logic       final_byte;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [5:0]  prefix_length;
        logic [31:0] destination_address;
        logic [31:0] router_address;
        logic [9:0]  route_index;
        logic        option_end;
    } t_out_word;

    // Number of destination octets that a prefix length calls for.
    function automatic logic [2:0] dest_octets(input logic [5:0] prefix);
        logic [6:0] sum;
        sum = {1'b0, prefix} + 7'd7;
        return sum[5:3];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/crop_in_stage.sv
`default_nettype none

module crop_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  crop_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  wire                 i_take,
    output crop_pkg::t_in_word  o_word
);

    logic               r_valid;
    logic               n_valid;
    crop_pkg::t_in_word r_word;

    // A new word may enter when the register is empty or is being taken.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        if (o_ready) begin
            n_valid = i_valid;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload register, loaded on each accepted word.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/crop_out_stage.sv
`default_nettype none

module crop_out_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  crop_pkg::t_out_word i_word,
    output logic                o_space,
    output logic                o_valid,
    input  wire                 i_ready,
    output crop_pkg::t_out_word o_word
);

    logic                r_valid;
    logic                n_valid;
    crop_pkg::t_out_word r_word;

    // The register has room when it is empty or its word leaves this cycle.
    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/crop_parse.sv
`default_nettype none

module crop_parse (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  crop_pkg::t_in_word  i_word,
    input  wire                 i_space,
    output logic                o_take,
    output logic                o_load,
    output crop_pkg::t_out_word o_word
);

    crop_pkg::t_phase r_phase;
    crop_pkg::t_phase n_phase;
    logic [5:0]       r_prefix;
    logic [5:0]       n_prefix;
    logic [2:0]       r_left;
    logic [2:0]       n_left;
    logic [31:0]      r_dest;
    logic [31:0]      n_dest;
    logic [23:0]      r_router;
    logic [23:0]      n_router;
    logic [9:0]       r_count;
    logic [9:0]       n_count;

    logic             emit;
    logic [7:0]       in_byte;
    logic             in_fin;
    logic [2:0]       nb_in;
    logic [2:0]       nb_held;
    logic [2:0]       left_dec;
    logic [31:0]      dest_shifted;

    // A word is consumed only when a result would have somewhere to go.
    assign o_take  = i_valid && i_space;
    assign o_load  = o_take && emit;
    assign in_byte = i_word.option_byte;
    assign in_fin  = i_word.final_byte;
    assign nb_in   = crop_pkg::dest_octets(in_byte[5:0]);
    assign nb_held = crop_pkg::dest_octets(r_prefix);
    assign left_dec = r_left - 3'd1;
    assign dest_shifted = {r_dest[23:0], in_byte};

    // Next state and result for the word at the head of the input register.
    always_comb begin
        n_phase  = r_phase;
        n_prefix = r_prefix;
        n_left   = r_left;
        n_dest   = r_dest;
        n_router = r_router;
        n_count  = r_count;
        emit     = 1'b0;
        o_word.result_kind         = crop_pkg::KIND_ROUTE;
        o_word.prefix_length       = 6'd0;
        o_word.destination_address = 32'd0;
        o_word.router_address      = 32'd0;
        o_word.route_index         = r_count;
        o_word.option_end          = in_fin;

        case (r_phase)
            crop_pkg::PH_PREFIX: begin
                if (in_byte > {2'b00, crop_pkg::MAX_PREFIX}) begin
                    emit               = 1'b1;
                    o_word.result_kind = crop_pkg::KIND_BAD_PREFIX;
                    n_phase            = crop_pkg::PH_DROP;
                    n_prefix           = 6'd0;
                    n_left             = 3'd0;
                    n_dest             = 32'd0;
                    n_router           = 24'd0;
                end else if (in_fin) begin
                    emit               = 1'b1;
                    o_word.result_kind = crop_pkg::KIND_OVERRUN;
                end else begin
                    n_prefix = in_byte[5:0];
                    n_dest   = 32'd0;
                    n_router = 24'd0;
                    if (nb_in == 3'd0) begin
                        n_phase = crop_pkg::PH_ROUTER;
                        n_left  = crop_pkg::ROUTER_OCTETS;
                    end else begin
                        n_phase = crop_pkg::PH_DEST;
                        n_left  = nb_in;
                    end
                end
            end
            crop_pkg::PH_DEST: begin
                if (in_fin) begin
                    emit               = 1'b1;
                    o_word.result_kind = crop_pkg::KIND_OVERRUN;
                end else begin
                    n_dest = dest_shifted;
                    n_left = left_dec;
                    if (left_dec == 3'd0) begin
                        // Pad the destination on the right to four octets.
                        case (nb_held)
                            3'd1:    n_dest = {dest_shifted[7:0], 24'd0};
                            3'd2:    n_dest = {dest_shifted[15:0], 16'd0};
                            3'd3:    n_dest = {dest_shifted[23:0], 8'd0};
                            default: n_dest = dest_shifted;
                        endcase
                        n_phase = crop_pkg::PH_ROUTER;
                        n_left  = crop_pkg::ROUTER_OCTETS;
                    end
                end
            end
            crop_pkg::PH_ROUTER: begin
                if (r_left <= 3'd1) begin
                    emit                       = 1'b1;
                    o_word.result_kind         = crop_pkg::KIND_ROUTE;
                    o_word.prefix_length       = r_prefix;
                    o_word.destination_address = r_dest;
                    o_word.router_address      = {r_router, in_byte};
                    if (r_count < crop_pkg::INDEX_MAX) begin
                        n_count = r_count + 10'd1;
                    end
                    n_phase  = crop_pkg::PH_PREFIX;
                    n_prefix = 6'd0;
                    n_left   = 3'd0;
                    n_dest   = 32'd0;
                    n_router = 24'd0;
                end else if (in_fin) begin
                    emit               = 1'b1;
                    o_word.result_kind = crop_pkg::KIND_OVERRUN;
                end else begin
                    n_router = {r_router[15:0], in_byte};
                    n_left   = left_dec;
                end
            end
            default: begin
                // Rest of a rejected option: nothing to report.
            end
        endcase

        // The final byte of an option returns everything to its reset state.
        if (in_fin) begin
            n_phase  = crop_pkg::PH_PREFIX;
            n_prefix = 6'd0;
            n_left   = 3'd0;
            n_dest   = 32'd0;
            n_router = 24'd0;
            n_count  = 10'd0;
        end
    end

    // State registers, updated on each consumed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= crop_pkg::PH_PREFIX;
            r_prefix <= 6'd0;
            r_left   <= 3'd0;
            r_dest   <= 32'd0;
            r_router <= 24'd0;
            r_count  <= 10'd0;
        end else if (o_take) begin
            r_phase  <= n_phase;
            r_prefix <= n_prefix;
            r_left   <= n_left;
            r_dest   <= n_dest;
            r_router <= n_router;
            r_count  <= n_count;
        end
    end

    // A held prefix never exceeds the largest legal length.
    a_prefix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prefix <= crop_pkg::MAX_PREFIX)
        else $error("held prefix above limit");

    // At most four octets are ever outstanding in one field.
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= crop_pkg::ROUTER_OCTETS)
        else $error("octet count out of range");

    // After a final byte the parser waits for a prefix with a cleared count.
    a_option_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && in_fin |=> r_phase == crop_pkg::PH_PREFIX && r_count == 10'd0)
        else $error("state not cleared after option end");

    // Error results carry no addresses.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load && o_word.result_kind != crop_pkg::KIND_ROUTE
        |-> o_word.destination_address == 32'd0 && o_word.router_address == 32'd0)
        else $error("error result carries address data");

endmodule

`default_nettype wire

FILE: rtl/classless_route_option_parser.sv
`default_nettype none

// Classless static route option parser. Bytes of one option arrive one word
// per cycle, with final_byte set on the last; each complete entry (prefix
// length, destination octets, four router octets) yields one route word, a
// prefix above 32 yields one bad-prefix word and the rest of the option is
// dropped, and an option ending inside an entry yields one overrun word.
// Throughput is one input word per cycle whenever the output side is ready.
// An accepted byte is held in the input register, then the parser state
// update loads its result word into the output register. A result
// word waiting at the output holds back the parser, and so the input, only
// while o_out_valid is high and i_out_ready is low.
module classless_route_option_parser (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  crop_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output crop_pkg::t_out_word o_out_word
);

    logic                stage_valid;
    crop_pkg::t_in_word  stage_word;
    logic                parse_take;
    logic                parse_load;
    logic                out_space;
    crop_pkg::t_out_word parse_word;

    crop_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .o_valid (stage_valid),
        .i_take  (parse_take),
        .o_word  (stage_word)
    );

    crop_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid),
        .i_word  (stage_word),
        .i_space (out_space),
        .o_take  (parse_take),
        .o_load  (parse_load),
        .o_word  (parse_word)
    );

    crop_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (parse_load),
        .i_word  (parse_word),
        .o_space (out_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

`default_nettype wire
